// ----- design/uoi_pkg.sv -----
`timescale 1ns / 1ps
package uoi_pkg;

	typedef enum logic [1:0] {
		REQ_CMD     = 2'd0,
		REQ_TICK    = 2'd1,
		REQ_RESTART = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_H = 2'd2;

	localparam int ATAN_ENTRIES = 24;
	localparam int CW = 34;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [20:0]   PI_Q16      = 21'sd205887;
	localparam logic signed [20:0]   TWO_PI_Q16  = 21'sd411775;

	function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
		logic signed [CW-1:0] r;
		case (i)
			5'd0: r = 34'sd843314857;
			5'd1: r = 34'sd497837829;
			5'd2: r = 34'sd263043837;
			5'd3: r = 34'sd133525159;
			5'd4: r = 34'sd67021687;
			5'd5: r = 34'sd33543516;
			5'd6: r = 34'sd16775851;
			5'd7: r = 34'sd8388437;
			5'd8: r = 34'sd4194283;
			5'd9: r = 34'sd2097149;
			5'd10: r = 34'sd1048576;
			5'd11: r = 34'sd524288;
			5'd12: r = 34'sd262144;
			5'd13: r = 34'sd131072;
			5'd14: r = 34'sd65536;
			5'd15: r = 34'sd32768;
			5'd16: r = 34'sd16384;
			5'd17: r = 34'sd8192;
			5'd18: r = 34'sd4096;
			5'd19: r = 34'sd2048;
			5'd20: r = 34'sd1024;
			5'd21: r = 34'sd512;
			5'd22: r = 34'sd256;
			5'd23: r = 34'sd128;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- design/uoi_if.sv -----
`timescale 1ns / 1ps
interface uoi_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [23:0] linear_speed;
	logic [23:0] turn_rate;
	logic [19:0] elapsed_time;
	logic [31:0] time_tag;
	modport source (output valid, req_type, linear_speed, turn_rate, elapsed_time, time_tag,
		input ready);
	modport sink (input valid, req_type, linear_speed, turn_rate, elapsed_time, time_tag,
		output ready);
endinterface

interface uoi_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [18:0] heading;
	logic [14:0] quat_w;
	logic [15:0] quat_z;
	logic [31:0] stamp_out;
	modport source (output valid, pos_x, pos_y, heading, quat_w, quat_z, stamp_out,
		input ready);
	modport sink (input valid, pos_x, pos_y, heading, quat_w, quat_z, stamp_out,
		output ready);
endinterface

// ----- design/unicycle_odometry_integrator.sv -----
`timescale 1ns / 1ps
// A tick's result is set by four serial multiplies, the iterative CORDIC and, when the new
// heading has to be wrapped, the serial wrap. Command and restart items produce no result.
// Throughput: one item at a time; after a tick the next item is taken once its result is gone.
// Reset (arst_n low) clears pose, speeds, start registers and all control state.
module unicycle_odometry_integrator
	import uoi_pkg::*;
#(
	parameter int CORDIC_STEPS  = 16,
	parameter int POS_FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	uoi_req_if.sink     req,
	uoi_res_if.source   res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	localparam int SH = 50 - POS_FRAC_BITS;

	// The sequencer walks through the tick's steps; each long step waits on a unit's done.
	typedef enum logic [10:0] {
		ST_IDLE   = 11'b00000000001,
		ST_VD     = 11'b00000000010,
		ST_COS    = 11'b00000000100,
		ST_MULX   = 11'b00000001000,
		ST_MULY   = 11'b00000010000,
		ST_TURN   = 11'b00000100000,
		ST_WRAP   = 11'b00001000000,
		ST_QUAT   = 11'b00010000000,
		ST_OUT    = 11'b00100000000,
		ST_WVD    = 11'b01000000000,
		ST_WAIT   = 11'b10000000000
	} state_t;

	state_t state_q;

	logic signed [31:0] start_x_q, start_y_q, pose_x_q, pose_y_q;
	logic signed [18:0] start_h_q, pose_h_q;
	logic signed [23:0] speed_q, turn_q;
	logic [19:0]        dt_q;
	logic [31:0]        tag_q;
	logic signed [44:0] vd_q;
	logic signed [21:0] cos18_q, sin18_q;
	logic signed [29:0] hsum_q;

	// Shared units.
	logic                 cd_start, cd_done;
	logic signed [CW-1:0] cd_angle, cd_cos, cd_sin;
	logic                 m_start, m_done;
	logic signed [44:0]   m_a;
	logic signed [23:0]   m_b;
	logic signed [68:0]   m_prod;

	uoi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .start(cd_start), .angle(cd_angle),
		.done(cd_done), .cos_out(cd_cos), .sin_out(cd_sin)
	);

	uoi_serial_mul #(.AW(45), .BW(24)) u_mul (
		.clk, .arst_n, .start(m_start), .a(m_a), .b(m_b),
		.done(m_done), .prod(m_prod)
	);

	// Result register.
	logic        rv_q;
	logic [31:0] ox_q, oy_q, otag_q;
	logic [18:0] oh_q;
	logic [14:0] ow_q;
	logic [15:0] oz_q;

	assign req.ready = (state_q == ST_IDLE) && !rv_q;
	wire accept = req.valid && req.ready;

	// Rounding helpers evaluated on the unit outputs.
	logic signed [CW-1:0] c12, s12, c15, s15;
	logic signed [68:0]   dprod;
	logic signed [29:0]   dturn;
	logic signed [47:0]   tprod;

	always_comb begin
		c12   = (cd_cos + 34'sd2048) >>> 12;
		s12   = (cd_sin + 34'sd2048) >>> 12;
		c15   = (cd_cos + 34'sd16384) >>> 15;
		s15   = (cd_sin + 34'sd16384) >>> 15;
		dprod = (m_prod + (69'sd1 <<< (SH - 1))) >>> SH;
		tprod = 48'(m_prod);
		dturn = 30'((tprod + 48'sd32768) >>> 16);
	end

	// Saturating add of the position step to a pose coordinate.
	function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
		input logic signed [68:0] d);
		logic signed [69:0] s;
		s = 70'(p) + 70'(d);
		if (s > 70'sd2147483647) return 32'sh7FFFFFFF;
		if (s < -70'sd2147483648) return 32'sh80000000;
		return s[31:0];
	endfunction

	// Wrap: a heading sum outside the half turn is offset to a positive value and reduced
	// modulo a full turn by a restoring remainder, one compare and subtract of a shifted
	// full turn per cycle, largest shift first. Nine shifts cover any turn rate and time.
	localparam logic [3:0] WRAP_SETUP = 4'd9;
	logic signed [29:0] wv_q, wturn, wnext;
	logic [3:0]         wk_q;
	logic               wup_q;

	always_comb begin
		wturn = 30'(TWO_PI_Q16) <<< wk_q;
		wnext = (wv_q >= wturn) ? wv_q - wturn : wv_q;
	end

	always_comb begin
		cd_start = 1'b0;
		cd_angle = '0;
		m_start  = 1'b0;
		m_a      = '0;
		m_b      = '0;
		case (state_q)
			ST_VD: begin
				m_start = 1'b1;
				m_a     = 45'($signed({1'b0, dt_q}));
				m_b     = speed_q;
				cd_start = 1'b1;
				cd_angle = CW'(pose_h_q) <<< 14;
			end
			ST_MULX: begin
				m_start = 1'b1;
				m_a     = vd_q;
				m_b     = 24'(cos18_q);
			end
			ST_MULY: begin
				m_start = 1'b1;
				m_a     = vd_q;
				m_b     = 24'(sin18_q);
			end
			ST_TURN: begin
				m_start = 1'b1;
				m_a     = 45'($signed({1'b0, dt_q}));
				m_b     = turn_q;
			end
			ST_QUAT: begin
				cd_start = 1'b1;
				cd_angle = CW'(pose_h_q) <<< 13;
			end
			default: ;
		endcase
	end

	logic cos_ok_q, phase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rv_q      <= 1'b0;
			start_x_q <= '0;
			start_y_q <= '0;
			start_h_q <= '0;
			pose_x_q  <= '0;
			pose_y_q  <= '0;
			pose_h_q  <= '0;
			speed_q   <= '0;
			turn_q    <= '0;
			cos_ok_q  <= 1'b0;
			phase_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_START_X: start_x_q <= cfg_data;
					CFG_START_Y: start_y_q <= cfg_data;
					CFG_START_H: start_h_q <= cfg_data[18:0];
					default: ;
				endcase
			end
			if (rv_q && res.ready) rv_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) begin
					case (req_t'(req.req_type))
						REQ_CMD: begin
							speed_q <= req.linear_speed;
							turn_q  <= req.turn_rate;
						end
						REQ_RESTART: begin
							pose_x_q <= start_x_q;
							pose_y_q <= start_y_q;
							pose_h_q <= start_h_q;
						end
						REQ_TICK: begin
							dt_q    <= req.elapsed_time;
							tag_q   <= req.time_tag;
							state_q <= ST_VD;
						end
						default: ;
					endcase
				end
				ST_VD: begin
					cos_ok_q <= 1'b0;
					state_q  <= ST_WVD;
				end
				ST_WVD: begin
					if (cd_done) begin
						cos18_q  <= c12[21:0];
						sin18_q  <= s12[21:0];
						cos_ok_q <= 1'b1;
					end
					if (m_done) begin
						vd_q    <= 45'(m_prod);
						state_q <= ST_COS;
					end
				end
				ST_COS: if (cos_ok_q || cd_done) begin
					if (cd_done) begin
						cos18_q <= c12[21:0];
						sin18_q <= s12[21:0];
					end
					state_q <= ST_MULX;
				end
				ST_MULX: state_q <= ST_WAIT;
				ST_WAIT: if (m_done) begin
					if (!phase_q) begin
						pose_x_q <= sat_add(pose_x_q, dprod);
						phase_q  <= 1'b1;
						state_q  <= ST_MULY;
					end else begin
						pose_y_q <= sat_add(pose_y_q, dprod);
						phase_q  <= 1'b0;
						state_q  <= ST_TURN;
					end
				end
				ST_MULY: state_q <= ST_WAIT;
				ST_TURN: state_q <= ST_WRAP;
				ST_WRAP: if (m_done) begin
					hsum_q  <= 30'(pose_h_q) + dturn;
					wk_q    <= WRAP_SETUP;
					state_q <= ST_OUT;
					phase_q <= 1'b1;
				end
				ST_OUT: begin
					if (phase_q) begin
						if (wk_q == WRAP_SETUP) begin
							if (hsum_q > 30'(PI_Q16)) begin
								wv_q  <= hsum_q + 30'(PI_Q16);
								wup_q <= 1'b1;
								wk_q  <= WRAP_SETUP - 4'd1;
							end else if (hsum_q < -30'(PI_Q16)) begin
								wv_q  <= 30'(PI_Q16) - hsum_q;
								wup_q <= 1'b0;
								wk_q  <= WRAP_SETUP - 4'd1;
							end else begin
								pose_h_q <= hsum_q[18:0];
								phase_q  <= 1'b0;
								state_q  <= ST_QUAT;
							end
						end else if (wk_q == 4'd0) begin
							pose_h_q <= wup_q ? 19'(wnext - 30'(PI_Q16)) :
								19'(30'(PI_Q16) - wnext);
							phase_q  <= 1'b0;
							state_q  <= ST_QUAT;
						end else begin
							wv_q <= wnext;
							wk_q <= wk_q - 4'd1;
						end
					end else if (cd_done) begin
						ox_q   <= pose_x_q;
						oy_q   <= pose_y_q;
						oh_q   <= pose_h_q;
						ow_q   <= c15 < 0 ? 15'd0 : (c15 > 34'sd32767 ? 15'd32767 : c15[14:0]);
						oz_q   <= s15 > 34'sd32767 ? 16'sd32767 :
							(s15 < -34'sd32767 ? -16'sd32767 : s15[15:0]);
						otag_q <= tag_q;
						rv_q   <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_QUAT: state_q <= ST_OUT;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res.valid     = rv_q;
	assign res.pos_x     = ox_q;
	assign res.pos_y     = oy_q;
	assign res.heading   = oh_q;
	assign res.quat_w    = ow_q;
	assign res.quat_z    = oz_q;
	assign res.stamp_out = otag_q;

`ifndef SYNTHESIS
	// A published heading always lies within minus pi to pi.
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ($signed(res.heading) <= 19'sd205887 &&
		$signed(res.heading) >= -19'sd205887))
		else $error("heading out of range");
	// No new item is taken while a result waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !req.ready)
		else $error("ready while result pending");
	// A result only appears at the end of a tick sequence.
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res.valid) |-> $past(state_q == ST_OUT))
		else $error("result without tick");
`endif
endmodule

// ----- design/uoi_cordic.sv -----
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
module uoi_cordic
	import uoi_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [CW-1:0] angle,
	output logic                 done,
	output logic signed [CW-1:0] cos_out,
	output logic signed [CW-1:0] sin_out
);
	localparam int NS = (STEPS < ATAN_ENTRIES) ? STEPS : ATAN_ENTRIES;

	logic signed [CW-1:0] x_q, y_q, a_q;
	logic                 neg_q, busy_q, done_q;
	logic [4:0]           i_q;
	logic signed [CW-1:0] a0;
	logic                 n0;

	always_comb begin
		n0 = 1'b1;
		if (angle > HALF_PI_Q30) a0 = angle - PI_Q30;
		else if (angle < -HALF_PI_Q30) a0 = angle + PI_Q30;
		else begin
			a0 = angle;
			n0 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				a_q    <= a0;
				neg_q  <= n0;
			end else if (busy_q) begin
				if (!a_q[CW-1]) begin
					x_q <= x_q - (y_q >>> i_q);
					y_q <= y_q + (x_q >>> i_q);
					a_q <= a_q - atan_q30(i_q);
				end else begin
					x_q <= x_q + (y_q >>> i_q);
					y_q <= y_q - (x_q >>> i_q);
					a_q <= a_q + atan_q30(i_q);
				end
				i_q <= i_q + 5'd1;
				if (i_q == 5'(NS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign cos_out = neg_q ? -x_q : x_q;
	assign sin_out = neg_q ? -y_q : y_q;
endmodule

// ----- design/uoi_serial_mul.sv -----
`timescale 1ns / 1ps
// Shift-add signed multiplier: one multiplier bit per cycle.
module uoi_serial_mul #(
	parameter int AW = 32,
	parameter int BW = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [AW-1:0]  a,
	input  logic signed [BW-1:0]  b,
	output logic                  done,
	output logic signed [AW+BW-1:0] prod
);
	localparam int CNT_W = $clog2(BW + 1);

	logic signed [AW+BW-1:0] acc_q, mcand_q;
	logic [BW-1:0]           mplr_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    busy_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				cnt_q   <= '0;
				acc_q   <= '0;
				mcand_q <= (AW+BW)'(a);
				mplr_q  <= b;
			end else if (busy_q) begin
				// Top bit of a two's-complement multiplier carries negative weight.
				if (mplr_q[0]) begin
					if (cnt_q == CNT_W'(BW - 1)) acc_q <= acc_q - mcand_q;
					else acc_q <= acc_q + mcand_q;
				end
				mcand_q <= mcand_q <<< 1;
				mplr_q  <= mplr_q >> 1;
				cnt_q   <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(BW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

// ----- sim/odometry_checker.sv -----
`timescale 1ns / 1ps
// Watches the request and result channels, keeps its own copy of the pose,
// predicts every tick result and compares it with what the block emits.
module odometry_checker
	import uoi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	uoi_req_if.sink     req,
	uoi_res_if.sink     res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          pending
);

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [18:0] hd;
		logic [14:0] qw;
		logic [15:0] qz;
		logic [31:0] stamp;
	} pose_report_t;

	localparam int STEPS = 16;
	localparam int FRAC = 16;

	pose_report_t poses_due[$];
	longint sx, sy, sh, px, py, ph, spd, trn;

	function automatic longint sra(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_sra(longint v, int s);
		return sra(v + (64'sd1 <<< (s - 1)), s);
	endfunction

	// Rotation from the gain vector; angles beyond a quarter turn are folded by a half turn.
	task automatic rotate(input longint ang, output longint c, output longint s);
		longint x, y, t;
		bit flip;
		x = CORDIC_GAIN;
		y = 0;
		flip = 0;
		if (ang > longint'(HALF_PI_Q30)) begin
			ang -= longint'(PI_Q30);
			flip = 1;
		end else if (ang < -longint'(HALF_PI_Q30)) begin
			ang += longint'(PI_Q30);
			flip = 1;
		end
		for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
			if (ang >= 0) begin
				t = x - sra(y, i);
				y = y + sra(x, i);
				ang -= longint'(atan_q30(5'(i)));
			end else begin
				t = x + sra(y, i);
				y = y - sra(x, i);
				ang += longint'(atan_q30(5'(i)));
			end
			x = t;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint wrap_angle(longint h);
		longint pi, tp;
		pi = PI_Q16;
		tp = TWO_PI_Q16;
		if (h > pi) return ((h + pi) % tp) - pi;
		if (h < -pi) return -((pi - h) % tp) + pi;
		return h;
	endfunction

	task automatic advance_pose(input logic [19:0] dt_in, input logic [31:0] tag);
		longint dt, vd, c, s, h, qw, qz;
		pose_report_t r;
		dt = dt_in;
		vd = spd * dt;
		rotate(ph * 16384, c, s);
		px = clip(px + round_sra(vd * round_sra(c, 12), 50 - FRAC), -(64'sd1 <<< 31),
			(64'sd1 <<< 31) - 1);
		py = clip(py + round_sra(vd * round_sra(s, 12), 50 - FRAC), -(64'sd1 <<< 31),
			(64'sd1 <<< 31) - 1);
		h = ph + round_sra(trn * dt, 16);
		ph = wrap_angle(h);
		rotate(ph * 8192, c, s);
		qw = clip(round_sra(c, 15), 0, 32767);
		qz = clip(round_sra(s, 15), -32767, 32767);
		r.px = px[31:0];
		r.py = py[31:0];
		r.hd = ph[18:0];
		r.qw = qw[14:0];
		r.qz = qz[15:0];
		r.stamp = tag;
		poses_due.push_back(r);
	endtask

	assign pending = poses_due.size();

	always @(posedge clk or negedge arst_n) begin
		pose_report_t want, got;
		if (!arst_n) begin
			sx = 0; sy = 0; sh = 0; px = 0; py = 0; ph = 0; spd = 0; trn = 0;
			mismatches <= 0;
			poses_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_START_X: sx = longint'($signed(cfg_data));
					CFG_START_Y: sy = longint'($signed(cfg_data));
					CFG_START_H: sh = longint'($signed(cfg_data[18:0]));
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				got = '{res.pos_x, res.pos_y, res.heading, res.quat_w, res.quat_z, res.stamp_out};
				if (poses_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected pose result %p", got);
					mismatches <= mismatches + 1;
				end else begin
					want = poses_due.pop_front();
					if (want != got) begin
						if (mismatches < 10)
							$display("pose mismatch: expected %p actual %p", want, got);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (req.valid && req.ready) begin
				case (req_t'(req.req_type))
					REQ_CMD: begin
						spd = longint'($signed(req.linear_speed));
						trn = longint'($signed(req.turn_rate));
					end
					REQ_RESTART: begin
						px = sx; py = sy; ph = sh;
					end
					REQ_TICK: advance_pose(req.elapsed_time, req.time_tag);
					default: ;
				endcase
			end
		end
	end

endmodule

// ----- sim/unicycle_odometry_integrator_test.sv -----
`timescale 1ns / 1ps
// Drives speed commands, ticks and restarts into the odometry block with random
// gaps on both sides; the checker alongside predicts and compares every pose.
module unicycle_odometry_integrator_test;
	import uoi_pkg::*;

	// This watchdog limit leaves many ticks of slack.
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 400;
	localparam int LONG_STALL = 1500;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [31:0] cfg_data;
	int          mismatches;
	int          pending;
	int          quiet_cycles;
	bit          calm;        // When set, neither side idles.
	bit          stall_req;   // Asks the receiver for one long stall.
	bit          stall_taken; // The receiver has started that stall.
	int          hold_off;    // Cycles the receiver still stalls outright.

	uoi_req_if req_ch();
	uoi_res_if res_ch();

	unicycle_odometry_integrator u_dut (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .res(res_ch.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	odometry_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req(req_ch.sink), .res(res_ch.sink),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	// The receiver stalls at random, or for a long stretch once stall_req is raised.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 0;
			hold_off <= 0;
			stall_taken <= 0;
		end else if (stall_req && !stall_taken) begin
			res_ch.ready <= 0;
			hold_off <= LONG_STALL;
			stall_taken <= 1;
		end else if (hold_off > 0) begin
			res_ch.ready <= 0;
			hold_off <= hold_off - 1;
		end else begin
			res_ch.ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	// The watchdog counts cycles where neither channel moves an item and no long stall runs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
				hold_off > 0)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Sends one item and holds it until the block takes it; idles before it at random.
	task automatic send(input req_t kind, input logic [23:0] spd, input logic [23:0] trn,
			input logic [19:0] dt, input logic [31:0] tag);
		while (!calm && $urandom_range(99) < 35) begin
			req_ch.valid <= 0;
			@(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.req_type <= kind;
		req_ch.linear_speed <= spd;
		req_ch.turn_rate <= trn;
		req_ch.elapsed_time <= dt;
		req_ch.time_tag <= tag;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// Idles the sender until every result is in, then lets the block settle.
	task automatic drain();
		req_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic [18:0] rand_heading();
		return 19'($signed($urandom_range(411774)) - 205887);
	endfunction

	initial begin
		logic [23:0] spd, trn;
		logic [19:0] dt;
		int pick;
		arst_n = 0;
		cfg_we = 0; cfg_idx = CFG_START_X; cfg_data = 0;
		req_ch.valid = 0; req_ch.req_type = REQ_CMD; req_ch.linear_speed = 0;
		req_ch.turn_rate = 0; req_ch.elapsed_time = 0; req_ch.time_tag = 0;
		calm = 0; stall_req = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: a tick from the reset pose, extreme speeds and times, the ignored
		// request code, and a restart from the far corners so that position saturates.
		write_reg(CFG_START_X, 32'h7FFF_0000);
		write_reg(CFG_START_Y, 32'h8000_0000);
		write_reg(CFG_START_H, 32'h0003_243F);
		send(REQ_TICK, 0, 0, 20'hFFFFF, 32'hFFFF_FFFF);
		send(REQ_CMD, 24'h7FFFFF, 24'h7FFFFF, 0, 0);
		send(REQ_TICK, 0, 0, 20'hFFFFF, 32'h0);
		send(REQ_NONE, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 32'hFFFF_FFFF);
		send(REQ_RESTART, 0, 0, 0, 0);
		send(REQ_TICK, 0, 0, 20'hFFFFF, 32'h1234_5678);
		send(REQ_CMD, 24'h800000, 24'h800000, 0, 0);
		send(REQ_TICK, 0, 0, 20'hFFFFF, 32'h8765_4321);
		send(REQ_TICK, 0, 0, 0, 32'h5555_5555);
		send(REQ_RESTART, 0, 0, 0, 0);
		send(REQ_TICK, 0, 0, 1, 32'hAAAA_AAAA);
		drain();

		// A heading register outside the half turn is loaded as is and wrapped later.
		write_reg(CFG_START_X, 32'h8000_0000);
		write_reg(CFG_START_Y, 32'h7FFF_FFFF);
		write_reg(CFG_START_H, 32'h0004_0000);
		send(REQ_RESTART, 0, 0, 0, 0);
		send(REQ_TICK, 0, 0, 20'h00100, 32'h1);
		drain();
		write_reg(CFG_START_H, 32'h0007_FFFF);
		write_reg(CFG_START_H, 32'h0003_0000);
		send(REQ_RESTART, 0, 0, 0, 0);
		send(REQ_TICK, 0, 0, 20'h00100, 32'h2);

		// The receiver holds off while the sender keeps offering ticks, filling the block.
		stall_req <= 1;
		for (int k = 0; k < 6; k++)
			send(REQ_TICK, 0, 0, 20'($urandom), $urandom);
		drain();

		// Random phases: each loads fresh start registers, then mixes commands, ticks,
		// restarts and the occasional stray code. One phase runs without idling.
		for (int phase = 0; phase < 7; phase++) begin
			write_reg(CFG_START_X, $urandom);
			write_reg(CFG_START_Y, $urandom);
			write_reg(CFG_START_H, {13'd0, rand_heading()});
			calm = (phase == 3);
			for (int n = 0; n < 250; n++) begin
				pick = $urandom_range(99);
				spd = 24'($urandom);
				trn = 24'($urandom);
				dt = 20'($urandom);
				// Mostly modest times and speeds keep the pose moving without pinning.
				if ($urandom_range(3) != 0) begin
					dt = 20'($urandom_range(6553));
					spd = 24'($signed($urandom_range(131072)) - 65536);
					trn = 24'($signed($urandom_range(262144)) - 131072);
				end
				if (pick < 20)
					send(REQ_CMD, spd, trn, dt, $urandom);
				else if (pick < 90)
					send(REQ_TICK, spd, trn, dt, $urandom);
				else if (pick < 97)
					send(REQ_RESTART, spd, trn, dt, $urandom);
				else
					send(REQ_NONE, spd, trn, dt, $urandom);
			end
			calm = 0;
			drain();
		end

		if (mismatches == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
